// File: hw/rtl/thermal_memory_pressure_monitor_top_assert.svh
// ----------------------------------------------------------------------------
// Thermal memory pressure monitor assertion macros
// Shared property templates, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef THERMAL_MEMORY_PRESSURE_MONITOR_TOP_ASSERT_SVH
`define THERMAL_MEMORY_PRESSURE_MONITOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TMPM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TMPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/tmpm_pkg.sv
// ----------------------------------------------------------------------------
// Thermal memory pressure monitor package
// Field widths, thresholds, register codes and the types shared by the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tmpm_pkg;

  localparam int TimeW = 32;
  localparam int MemW  = 16;
  localparam int TempW = 18;
  localparam int RateW = 19;
  localparam int CritW = 9;
  localparam int HmbW  = 17;
  localparam int SttW  = 18;

  localparam int DataW  = 32;
  localparam int PaddrW = 4;

  // Elapsed milliseconds to whole seconds: x / 1000 == (x * MsMagic) >> MsShift
  // for every 32-bit x.
  localparam int                MagicW  = 29;
  localparam logic [MagicW-1:0] MsMagic = 29'd274877907;
  localparam int                MsShift = 38;
  localparam int                ProdW   = TimeW + MagicW;
  localparam int                DtW     = ProdW - MsShift;

  localparam int DivDvdW = TempW;
  localparam int DivDsrW = DtW;
  localparam int DivCntW = $clog2(DivDvdW + 1);

  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic signed [RateW-1:0] RateSurge = 19'sd200;
  localparam logic signed [RateW-1:0] RateRise  = 19'sd50;
  localparam logic signed [RateW-1:0] RateCool  = -19'sd50;

  localparam logic signed [HmbW-1:0] HmbGreen  = 17'sd1024;
  localparam logic signed [HmbW-1:0] HmbYellow = 17'sd512;
  localparam logic signed [HmbW-1:0] HmbRed    = 17'sd128;

  localparam logic [SttW-1:0] SttNone = 18'd999;

  localparam logic [TempW-1:0] ThrottleRst = 18'd80000;
  localparam logic [MemW-1:0]  ReservedRst = 16'd512;
  localparam logic [CritW-1:0] CriticalRst = 9'd256;

  typedef enum logic [1:0] {
    RegThrottle = 2'd0,
    RegReserved = 2'd1,
    RegCritical = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    TrajCooling = 2'd0,
    TrajStable  = 2'd1,
    TrajRising  = 2'd2,
    TrajSurging = 2'd3
  } traj_e;

  typedef enum logic [2:0] {
    PresGreen    = 3'd0,
    PresYellow   = 3'd1,
    PresOrange   = 3'd2,
    PresRed      = 3'd3,
    PresCritical = 3'd4
  } pres_e;

  // One classified sample waiting for the rate and throttle divisions.
  typedef struct packed {
    logic [MemW-1:0]         used;
    logic [TempW-1:0]        cur;
    pres_e                   pres;
    logic                    has_rate;
    logic [TimeW-1:0]        elapsed;
    logic signed [RateW-1:0] dtemp;
    logic signed [RateW-1:0] head;
  } job_t;

  typedef struct packed {
    logic               start;
    logic [DivDvdW-1:0] dividend;
    logic [DivDsrW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DivDvdW-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/thermal_memory_pressure_monitor_top.sv
// ----------------------------------------------------------------------------
// Thermal memory pressure monitor
// Per-sample memory use, temperature trend, throttle time and memory pressure.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the in_valid_i / in_ready_o channel, one word per sample,
//   and each produces exactly one result word on out_valid_o / out_ready_i.
//   The front end classifies a sample in the cycle it is accepted and places
//   it in a two-entry queue, so samples are taken while the back end works.
//   The back end works on one sample at a time: it scales the elapsed time,
//   then runs the rate and throttle divisions, each a pass of the shared
//   serial divider (one quotient bit per cycle, 18 bits). Either division
//   may be skipped; the divider sets the sustained rate. A stalled receiver
//   holds the result register, the back end waits with the next finished
//   sample, and the queue then fills before in_ready_o drops.
//   Reset clears the sample history and count and returns the registers to
//   throttle 80000 m degC, reserved 512 MB and critical 256 MB. Registers are
//   to be written by the user through the APB port only while no sample is
//   in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module thermal_memory_pressure_monitor_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tmpm_pkg::PaddrW-1:0]  paddr,
  input  wire logic [tmpm_pkg::DataW-1:0]   pwdata,
  output logic [tmpm_pkg::DataW-1:0]        prdata,
  output logic                              pready,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [tmpm_pkg::TimeW-1:0]   time_ms_i,
  input  wire logic [tmpm_pkg::MemW-1:0]    available_mb_i,
  input  wire logic [tmpm_pkg::MemW-1:0]    total_mb_i,
  input  wire logic [tmpm_pkg::TempW-1:0]   gpu_temp_mc_i,
  input  wire logic [tmpm_pkg::TempW-1:0]   junction_temp_mc_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [tmpm_pkg::MemW-1:0]         used_mb_o,
  output logic [tmpm_pkg::TempW-1:0]        peak_temp_mc_o,
  output logic signed [tmpm_pkg::RateW-1:0] temp_rate_o,
  output logic [1:0]                        trajectory_o,
  output logic [tmpm_pkg::SttW-1:0]         throttle_eta_s_o,
  output logic [2:0]                        pressure_o
);

  logic [tmpm_pkg::TempW-1:0]  throttle_q;
  logic [tmpm_pkg::MemW-1:0]   reserved_q;
  logic [tmpm_pkg::CritW-1:0]  critical_q;
  tmpm_pkg::reg_idx_e          reg_idx;
  logic                        reg_wr;

  logic                        push_valid, push_ready;
  tmpm_pkg::job_t              push_data;
  logic                        pop_valid, pop_ready;
  tmpm_pkg::job_t              pop_data;
  tmpm_pkg::div_req_t          div_req;
  tmpm_pkg::div_rsp_t          div_rsp;

  assign pready  = 1'b1;
  assign reg_idx = tmpm_pkg::reg_idx_e'(paddr[tmpm_pkg::PaddrW-1:2]);
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      throttle_q <= tmpm_pkg::ThrottleRst;
      reserved_q <= tmpm_pkg::ReservedRst;
      critical_q <= tmpm_pkg::CriticalRst;
    end else if (reg_wr) begin
      case (reg_idx)
        tmpm_pkg::RegThrottle: throttle_q <= pwdata[tmpm_pkg::TempW-1:0];
        tmpm_pkg::RegReserved: reserved_q <= pwdata[tmpm_pkg::MemW-1:0];
        tmpm_pkg::RegCritical: critical_q <= pwdata[tmpm_pkg::CritW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tmpm_pkg::RegThrottle: prdata = tmpm_pkg::DataW'(throttle_q);
      tmpm_pkg::RegReserved: prdata = tmpm_pkg::DataW'(reserved_q);
      tmpm_pkg::RegCritical: prdata = tmpm_pkg::DataW'(critical_q);
      default:               prdata = '0;
    endcase
  end

  tmpm_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .time_ms_i          (time_ms_i),
    .available_mb_i     (available_mb_i),
    .total_mb_i         (total_mb_i),
    .gpu_temp_mc_i      (gpu_temp_mc_i),
    .junction_temp_mc_i (junction_temp_mc_i),
    .throttle_temp_mc_i (throttle_q),
    .reserved_mb_i      (reserved_q),
    .critical_mb_i      (critical_q),
    .push_valid_o       (push_valid),
    .push_ready_i       (push_ready),
    .push_data_o        (push_data)
  );

  tmpm_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  tmpm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  tmpm_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_valid_i      (pop_valid),
    .job_ready_o      (pop_ready),
    .job_i            (pop_data),
    .div_req_o        (div_req),
    .div_rsp_i        (div_rsp),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .used_mb_o        (used_mb_o),
    .peak_temp_mc_o   (peak_temp_mc_o),
    .temp_rate_o      (temp_rate_o),
    .trajectory_o     (trajectory_o),
    .throttle_eta_s_o (throttle_eta_s_o),
    .pressure_o       (pressure_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/tmpm_div.sv
// ----------------------------------------------------------------------------
// Serial unsigned divider
// Restoring division, one quotient bit per cycle; done pulses when finished.
// ----------------------------------------------------------------------------
`default_nettype none

module tmpm_div (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tmpm_pkg::div_req_t  req_i,
  output tmpm_pkg::div_rsp_t       rsp_o
);

  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic [tmpm_pkg::DivCntW-1:0]     cnt_q, cnt_d;
  logic [tmpm_pkg::DivDsrW-1:0]     rem_q, rem_d;
  logic [tmpm_pkg::DivDsrW-1:0]     dsr_q, dsr_d;
  logic [tmpm_pkg::DivDvdW-1:0]     dvd_q, dvd_d;
  logic [tmpm_pkg::DivDsrW:0]       trial;
  logic [tmpm_pkg::DivDsrW:0]       diff;
  logic                             ge;

  assign trial = {rem_q, dvd_q[tmpm_pkg::DivDvdW-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    dvd_d  = dvd_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = tmpm_pkg::DivCntW'(tmpm_pkg::DivDvdW);
      rem_d  = '0;
      dsr_d  = req_i.divisor;
      dvd_d  = req_i.dividend;
    end else if (busy_q) begin
      // The partial remainder stays below the divisor, so it fits its width.
      rem_d = ge ? diff[tmpm_pkg::DivDsrW-1:0] : trial[tmpm_pkg::DivDsrW-1:0];
      dvd_d = {dvd_q[tmpm_pkg::DivDvdW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == tmpm_pkg::DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    dvd_q <= dvd_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule

`default_nettype wire

// File: hw/rtl/tmpm_fifo.sv
// ----------------------------------------------------------------------------
// Sample queue
// Short FIFO between the classifying front end and the division back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tmpm_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_valid_i,
  output logic                 push_ready_o,
  input  wire tmpm_pkg::job_t  push_data_i,
  output logic                 pop_valid_o,
  input  wire logic            pop_ready_i,
  output tmpm_pkg::job_t       pop_data_o
);

  tmpm_pkg::job_t               mem_q [tmpm_pkg::QDepth];
  logic [tmpm_pkg::QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [tmpm_pkg::QCntW-1:0]   cnt_q;
  logic                         push, pop;

  assign push_ready_o = cnt_q != tmpm_pkg::QCntW'(tmpm_pkg::QDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == tmpm_pkg::QPtrW'(tmpm_pkg::QDepth - 1)) ? '0
                                                                       : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == tmpm_pkg::QPtrW'(tmpm_pkg::QDepth - 1)) ? '0
                                                                       : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tmpm_front.sv
// ----------------------------------------------------------------------------
// Sample front end
// Accepts samples, keeps the two-sample history and classifies each sample.
// ----------------------------------------------------------------------------
`default_nettype none

module tmpm_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [tmpm_pkg::TimeW-1:0]  time_ms_i,
  input  wire logic [tmpm_pkg::MemW-1:0]   available_mb_i,
  input  wire logic [tmpm_pkg::MemW-1:0]   total_mb_i,
  input  wire logic [tmpm_pkg::TempW-1:0]  gpu_temp_mc_i,
  input  wire logic [tmpm_pkg::TempW-1:0]  junction_temp_mc_i,
  input  wire logic [tmpm_pkg::TempW-1:0]  throttle_temp_mc_i,
  input  wire logic [tmpm_pkg::MemW-1:0]   reserved_mb_i,
  input  wire logic [tmpm_pkg::CritW-1:0]  critical_mb_i,
  output logic                             push_valid_o,
  input  wire logic                        push_ready_i,
  output tmpm_pkg::job_t                   push_data_o
);

  logic [tmpm_pkg::TimeW-1:0]        past_time_q [2];
  logic [tmpm_pkg::TempW-1:0]        past_temp_q [2];
  logic [1:0]                        count_q;
  logic                              accept;
  logic [tmpm_pkg::TempW-1:0]        cur;
  logic signed [tmpm_pkg::HmbW-1:0]  hmb;
  logic signed [tmpm_pkg::HmbW-1:0]  crit;
  tmpm_pkg::pres_e                   pres;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i && push_ready_i;

  assign cur  = (junction_temp_mc_i > gpu_temp_mc_i) ? junction_temp_mc_i : gpu_temp_mc_i;
  assign hmb  = $signed({1'b0, available_mb_i}) - $signed({1'b0, reserved_mb_i});
  assign crit = $signed(tmpm_pkg::HmbW'(critical_mb_i));

  always_comb begin
    if (hmb > tmpm_pkg::HmbGreen) begin
      pres = tmpm_pkg::PresGreen;
    end else if (hmb > tmpm_pkg::HmbYellow) begin
      pres = tmpm_pkg::PresYellow;
    end else if (hmb > crit) begin
      pres = tmpm_pkg::PresOrange;
    end else if (hmb > tmpm_pkg::HmbRed) begin
      pres = tmpm_pkg::PresRed;
    end else begin
      pres = tmpm_pkg::PresCritical;
    end
  end

  always_comb begin
    push_data_o.used     = (total_mb_i > available_mb_i) ? total_mb_i - available_mb_i : '0;
    push_data_o.cur      = cur;
    push_data_o.pres     = pres;
    // This sample is the third or later once the count has reached two.
    push_data_o.has_rate = count_q[1];
    push_data_o.elapsed  = time_ms_i - past_time_q[1];
    push_data_o.dtemp    = $signed({1'b0, cur}) - $signed({1'b0, past_temp_q[1]});
    push_data_o.head     = $signed({1'b0, throttle_temp_mc_i}) - $signed({1'b0, cur});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      past_time_q[0] <= '0;
      past_time_q[1] <= '0;
      past_temp_q[0] <= '0;
      past_temp_q[1] <= '0;
      count_q        <= '0;
    end else if (accept) begin
      past_time_q[1] <= past_time_q[0];
      past_temp_q[1] <= past_temp_q[0];
      past_time_q[0] <= time_ms_i;
      past_temp_q[0] <= cur;
      if (count_q != 2'd3) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tmpm_back.sv
// ----------------------------------------------------------------------------
// Division back end
// Scales elapsed time to seconds, runs the rate and throttle divisions on the
// shared serial divider and holds the finished result word.
// ----------------------------------------------------------------------------
`default_nettype none

`include "thermal_memory_pressure_monitor_top_assert.svh"

module tmpm_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         job_valid_i,
  output logic                              job_ready_o,
  input  wire tmpm_pkg::job_t               job_i,
  output tmpm_pkg::div_req_t                div_req_o,
  input  wire tmpm_pkg::div_rsp_t           div_rsp_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [tmpm_pkg::MemW-1:0]         used_mb_o,
  output logic [tmpm_pkg::TempW-1:0]        peak_temp_mc_o,
  output logic signed [tmpm_pkg::RateW-1:0] temp_rate_o,
  output logic [1:0]                        trajectory_o,
  output logic [tmpm_pkg::SttW-1:0]         throttle_eta_s_o,
  output logic [2:0]                        pressure_o
);

  typedef enum logic [6:0] {
    SIdle  = 7'b0000001,
    SMul   = 7'b0000010,
    SScale = 7'b0000100,
    SRate  = 7'b0001000,
    SHead  = 7'b0010000,
    SStt   = 7'b0100000,
    SFin   = 7'b1000000
  } state_e;

  state_e                             state_q, state_d;
  tmpm_pkg::job_t                     job_q, job_d;
  logic [tmpm_pkg::ProdW-1:0]         prod_q, prod_d;
  logic signed [tmpm_pkg::RateW-1:0]  rate_q, rate_d;
  logic [tmpm_pkg::SttW-1:0]          stt_q, stt_d;
  logic                               out_valid_q, out_valid_d;
  logic                               load;
  logic [tmpm_pkg::DtW-1:0]           dt;
  logic [tmpm_pkg::RateW-1:0]         dtemp_mag;
  logic signed [tmpm_pkg::RateW-1:0]  quo_s;
  tmpm_pkg::traj_e                    traj;

  logic [tmpm_pkg::MemW-1:0]          used_q;
  logic [tmpm_pkg::TempW-1:0]         cur_q;
  logic signed [tmpm_pkg::RateW-1:0]  rate_out_q;
  tmpm_pkg::traj_e                    traj_q;
  logic [tmpm_pkg::SttW-1:0]          stt_out_q;
  tmpm_pkg::pres_e                    pres_q;

  assign dt          = prod_q[tmpm_pkg::ProdW-1:tmpm_pkg::MsShift];
  assign dtemp_mag   = job_q.dtemp[tmpm_pkg::RateW-1] ? tmpm_pkg::RateW'(-job_q.dtemp)
                                                      : tmpm_pkg::RateW'(job_q.dtemp);
  assign quo_s       = $signed({1'b0, div_rsp_i.quotient});
  assign job_ready_o = state_q == SIdle;

  always_comb begin
    if (rate_q > tmpm_pkg::RateSurge) begin
      traj = tmpm_pkg::TrajSurging;
    end else if (rate_q > tmpm_pkg::RateRise) begin
      traj = tmpm_pkg::TrajRising;
    end else if (rate_q < tmpm_pkg::RateCool) begin
      traj = tmpm_pkg::TrajCooling;
    end else begin
      traj = tmpm_pkg::TrajStable;
    end
  end

  always_comb begin
    state_d            = state_q;
    job_d              = job_q;
    prod_d             = prod_q;
    rate_d             = rate_q;
    stt_d              = stt_q;
    load               = 1'b0;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = dtemp_mag[tmpm_pkg::DivDvdW-1:0];
    div_req_o.divisor  = dt;
    case (state_q)
      SIdle: begin
        if (job_valid_i) begin
          job_d   = job_i;
          state_d = SMul;
        end
      end
      SMul: begin
        prod_d  = tmpm_pkg::ProdW'(job_q.elapsed) * tmpm_pkg::ProdW'(tmpm_pkg::MsMagic);
        state_d = SScale;
      end
      SScale: begin
        if (job_q.has_rate && (dt != '0)) begin
          div_req_o.start = 1'b1;
          state_d         = SRate;
        end else begin
          rate_d  = '0;
          state_d = SHead;
        end
      end
      SRate: begin
        if (div_rsp_i.done) begin
          rate_d  = job_q.dtemp[tmpm_pkg::RateW-1] ? -quo_s : quo_s;
          state_d = SHead;
        end
      end
      SHead: begin
        div_req_o.dividend = job_q.head[tmpm_pkg::DivDvdW-1:0];
        div_req_o.divisor  = tmpm_pkg::DivDsrW'(rate_q[tmpm_pkg::DivDvdW-1:0]);
        if ((rate_q > 19'sd0) && (job_q.head > 19'sd0)) begin
          div_req_o.start = 1'b1;
          state_d         = SStt;
        end else begin
          stt_d   = tmpm_pkg::SttNone;
          state_d = SFin;
        end
      end
      SStt: begin
        if (div_rsp_i.done) begin
          stt_d   = div_rsp_i.quotient;
          state_d = SFin;
        end
      end
      SFin: begin
        // The result register may still hold the previous word.
        if (!out_valid_q || out_ready_i) begin
          load    = 1'b1;
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  assign out_valid_d = load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    prod_q <= prod_d;
    rate_q <= rate_d;
    stt_q  <= stt_d;
    if (load) begin
      used_q     <= job_q.used;
      cur_q      <= job_q.cur;
      rate_out_q <= rate_q;
      traj_q     <= traj;
      stt_out_q  <= stt_q;
      pres_q     <= job_q.pres;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign used_mb_o        = used_q;
  assign peak_temp_mc_o   = cur_q;
  assign temp_rate_o      = rate_out_q;
  assign trajectory_o     = traj_q;
  assign throttle_eta_s_o = stt_out_q;
  assign pressure_o       = pres_q;

  `TMPM_ASSERT_IMPL(a_div_start_step, div_req_o.start, (state_q == SScale) || (state_q == SHead), "divider started outside a dispatch step")
  `TMPM_ASSERT_IMPL(a_div_idle_on_start, div_req_o.start, !div_rsp_i.busy, "divider started while busy")
  `TMPM_ASSERT_NEXT(a_load_sets_valid, load, out_valid_q, "loaded result word not presented")
  `TMPM_ASSERT_IMPL(a_stt_none_rate, out_valid_q && (rate_out_q <= 19'sd0), stt_out_q == tmpm_pkg::SttNone, "throttle time given without a rising rate")

endmodule

`default_nettype wire
